// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file.
// Plain text only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked out of reset only.
`define DPDS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dpds assertion failed");

// Checked on every edge, reset included.
`define DPDS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dpds assertion failed");

`endif

// ===== hw/rtl/dpds_pkg.sv =====
// Shared widths, sequencer codes and helpers for the dipole potential block.
// No dependencies.
package dpds_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int SQRT_GUARD  = 16;
  localparam int NORMAL_FRAC = 30;

  localparam int MUL_W  = 33;                      // shared multiplier operand width
  localparam int PROD_W = 2 * MUL_W;
  localparam int D_W    = 33;                      // target - source, signed
  localparam int R2_W   = 66;                      // |D|^2 < 3 * 2^64
  localparam int DOT_W  = 67;                      // signed dot product
  localparam int DMAG_W = 65;                      // |dot| <= 3 * 2^63
  localparam int NUM_W  = 97;
  localparam int RAD_W  = R2_W + 2 * SQRT_GUARD;   // sqrt radicand
  localparam int ROOT_W = RAD_W / 2;
  localparam int DEN_W  = R2_W + ROOT_W;
  localparam int DIV_SHIFT = FRAC_BITS + 32 - NORMAL_FRAC + SQRT_GUARD;
  localparam int DVD_W  = NUM_W + DIV_SHIFT;
  localparam int SQ_CNT_W  = $clog2(ROOT_W + 1);
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_CHECK, ST_SQRT, ST_DIVGO, ST_DIV, ST_SUM, ST_FIN
  } state_t;

  // Product schedule of the shared multiplier.
  typedef enum logic [3:0] {
    MS_RX, MS_RY, MS_RZ, MS_DX, MS_DY, MS_DZ,
    MS_NLO, MS_NHI, MS_D00, MS_D01, MS_D10, MS_D11
  } mstep_t;

  typedef struct packed {
    logic start;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
  } unit_stat_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63])
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s;
  endfunction

endpackage

// ===== hw/rtl/dipole_potential_direct_sum.sv =====
// Top level: sequencer, shared multiplier schedule and Q32.32 accumulator.
// Depends on dpds_pkg, dpds_mul, dpds_sqrt, dpds_div.
//
//  channel | direction | handshake          | word
//  in      | input     | in_valid/in_stall  | target, source, normal, density, last
//  out     | output    | out_valid/out_stall| potential, coincident_seen
//
// One source word runs 12 products on the shared 33x33 multiplier, a 49-step square
// root and a 131-step divider, one bit a cycle.
// A coincident source (zero distance) skips the last six products, the root and the divider.
// in_stall is low only in the idle state: it is high from accept until the sequencer is idle again.
// A last word waits in the final state while a previous result is still stalled.
// Synchronous reset clears the sum, the flag and out_valid.
module dipole_potential_direct_sum import dpds_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  input  logic signed [31:0] source_x,
  input  logic signed [31:0] source_y,
  input  logic signed [31:0] source_z,
  input  logic signed [31:0] normal_x,
  input  logic signed [31:0] normal_y,
  input  logic signed [31:0] normal_z,
  input  logic signed [31:0] density,
  input  logic               last_source,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] potential,
  output logic               coincident_seen
);

  state_t state, state_next;
  mstep_t step;
  logic   ph;

  logic [D_W-1:0]  dx, dy, dz;
  logic [31:0]     nx, ny, nz, dens;
  logic            last;
  logic [R2_W-1:0] r2;
  logic [DOT_W-1:0] dot;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic [63:0]     sum_acc;
  logic            sticky;

  logic [D_W-1:0]    dmx, dmy, dmz;
  logic [31:0]       nmx, nmy, nmz, dmag;
  logic [DMAG_W-1:0] dotmag;
  logic [DOT_W-1:0]  dotneg_v;
  logic              neg;
  logic [MUL_W-1:0]  op_a, op_b;
  logic [PROD_W-1:0] prod;
  logic [ROOT_W-1:0] root;
  logic [63:0]       mag, term;
  logic              sgn;
  unit_ctl_t         sq_ctl, dv_ctl;
  unit_stat_t        sq_stat, dv_stat;
  logic              accept, out_free;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    dmx      = dx[D_W-1] ? -dx : dx;
    dmy      = dy[D_W-1] ? -dy : dy;
    dmz      = dz[D_W-1] ? -dz : dz;
    nmx      = nx[31] ? -nx : nx;
    nmy      = ny[31] ? -ny : ny;
    nmz      = nz[31] ? -nz : nz;
    dmag     = dens[31] ? -dens : dens;
    dotneg_v = -dot;
    dotmag   = dot[DOT_W-1] ? dotneg_v[DMAG_W-1:0] : dot[DMAG_W-1:0];
    neg      = dot[DOT_W-1] ^ dens[31];
    term     = neg ? (~mag + 64'd1) : (mag[63] ? {1'b0, {63{1'b1}}} : mag);
  end

  // Operand select and product sign for the current schedule step.
  always_comb begin
    op_a = '0;
    op_b = '0;
    sgn  = 1'b0;
    case (step)
      MS_RX:  begin op_a = dmx; op_b = dmx; end
      MS_RY:  begin op_a = dmy; op_b = dmy; end
      MS_RZ:  begin op_a = dmz; op_b = dmz; end
      MS_DX:  begin op_a = dmx; op_b = {1'b0, nmx}; sgn = dx[D_W-1] ^ nx[31]; end
      MS_DY:  begin op_a = dmy; op_b = {1'b0, nmy}; sgn = dy[D_W-1] ^ ny[31]; end
      MS_DZ:  begin op_a = dmz; op_b = {1'b0, nmz}; sgn = dz[D_W-1] ^ nz[31]; end
      MS_NLO: begin op_a = dotmag[32:0]; op_b = {1'b0, dmag}; end
      MS_NHI: begin op_a = {1'b0, dotmag[64:33]}; op_b = {1'b0, dmag}; end
      MS_D00: begin op_a = r2[32:0]; op_b = root[32:0]; end
      MS_D01: begin op_a = r2[32:0]; op_b = {17'd0, root[48:33]}; end
      MS_D10: begin op_a = r2[65:33]; op_b = root[32:0]; end
      MS_D11: begin op_a = r2[65:33]; op_b = {17'd0, root[48:33]}; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  dpds_mul u_mul (.clk(clk), .a(op_a), .b(op_b), .p(prod));

  dpds_sqrt u_sqrt (
    .clk(clk), .rst(rst), .ctl(sq_ctl), .r2(r2), .stat(sq_stat), .root(root)
  );

  dpds_div u_div (
    .clk(clk), .rst(rst), .ctl(dv_ctl), .num(num), .den(den), .stat(dv_stat), .mag(mag)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next   = state;
    in_stall     = 1'b1;
    sq_ctl.start = 1'b0;
    dv_ctl.start = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_next = ST_MUL;
      end
      ST_MUL: begin
        if (ph) begin
          case (step)
            MS_DZ:  state_next = ST_CHECK;
            MS_NHI: state_next = ST_SQRT;
            MS_D11: state_next = ST_DIVGO;
            default: state_next = ST_MUL;
          endcase
        end
      end
      ST_CHECK: begin
        if (r2 == '0) begin
          state_next = ST_FIN;
        end else begin
          sq_ctl.start = 1'b1;
          state_next   = ST_MUL;
        end
      end
      ST_SQRT:  if (!sq_stat.busy) state_next = ST_MUL;
      ST_DIVGO: begin
        dv_ctl.start = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV:   if (!dv_stat.busy) state_next = ST_SUM;
      ST_SUM:   state_next = ST_FIN;
      ST_FIN:   if (!last || out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= MS_RX;
      ph        <= 1'b0;
      sum_acc   <= '0;
      sticky    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a last word in the final state loads the output register itself
      if (out_valid && !out_stall && !(state == ST_FIN && last)) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            dx   <= {target_x[31], target_x} - {source_x[31], source_x};
            dy   <= {target_y[31], target_y} - {source_y[31], source_y};
            dz   <= {target_z[31], target_z} - {source_z[31], source_z};
            nx   <= normal_x;
            ny   <= normal_y;
            nz   <= normal_z;
            dens <= density;
            last <= last_source;
            r2   <= '0;
            dot  <= '0;
            step <= MS_RX;
            ph   <= 1'b0;
          end
        end
        ST_MUL: begin
          ph <= ~ph;
          if (ph) begin
            case (step)
              MS_RX, MS_RY, MS_RZ: r2 <= r2 + R2_W'(prod);
              MS_DX, MS_DY, MS_DZ: dot <= sgn ? dot - DOT_W'(prod) : dot + DOT_W'(prod);
              MS_NLO: num <= NUM_W'(prod);
              MS_NHI: num <= num + (NUM_W'(prod) << 33);
              MS_D00: den <= DEN_W'(prod);
              MS_D01, MS_D10: den <= den + (DEN_W'(prod) << 33);
              MS_D11: den <= den + (DEN_W'(prod) << 66);
              default: r2 <= r2;
            endcase
            if (step != MS_DZ && step != MS_NHI && step != MS_D11)
              step <= mstep_t'(step + 4'd1);
          end
        end
        ST_CHECK: begin
          if (r2 == '0) sticky <= 1'b1;
          step <= MS_NLO;
          ph   <= 1'b0;
        end
        ST_SQRT: begin
          step <= MS_D00;
          ph   <= 1'b0;
        end
        ST_SUM: sum_acc <= sat_add(sum_acc, term);
        ST_FIN: begin
          if (last && out_free) begin
            out_valid       <= 1'b1;
            potential       <= sum_acc;
            coincident_seen <= sticky;
            sum_acc         <= '0;
            sticky          <= 1'b0;
          end
        end
        default: ph <= ph;
      endcase
    end
  end

endmodule

// ===== hw/rtl/dpds_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on dpds_pkg.
module dpds_mul import dpds_pkg::*; (
  input  logic              clk,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

// ===== hw/rtl/dpds_sqrt.sv =====
// Digit-by-digit integer square root of r2 * 2^(2*SQRT_GUARD), one root bit a cycle.
// Depends on dpds_pkg.
module dpds_sqrt import dpds_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  unit_ctl_t         ctl,
  input  logic [R2_W-1:0]   r2,
  output unit_stat_t        stat,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_W-1:0]    rad;
  logic [ROOT_W+1:0]   rem;
  logic [SQ_CNT_W-1:0] cnt;
  logic                busy;
  logic [ROOT_W+3:0]   rem_sh;
  logic [ROOT_W+3:0]   trial;
  logic                ge;

  always_comb begin
    rem_sh = {rem, rad[RAD_W-1 -: 2]};
    trial  = {2'b00, root, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      cnt  <= SQ_CNT_W'(ROOT_W);
      rad  <= {r2, {(2 * SQRT_GUARD){1'b0}}};
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad << 2;
      rem  <= ge ? (ROOT_W+2)'(rem_sh - trial) : (ROOT_W+2)'(rem_sh);
      root <= {root[ROOT_W-2:0], ge};
      cnt  <= cnt - 1'b1;
      if (cnt == SQ_CNT_W'(1)) busy <= 1'b0;
    end
  end

  assign stat.busy = busy;

endmodule

// ===== hw/rtl/dpds_div.sv =====
// Restoring divider: floor(num * 2^DIV_SHIFT / den), one quotient bit a cycle,
// magnitude capped at 2^63. Depends on dpds_pkg.
module dpds_div import dpds_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  unit_ctl_t          ctl,
  input  logic [NUM_W-1:0]   num,
  input  logic [DEN_W-1:0]   den,
  output unit_stat_t         stat,
  output logic [63:0]        mag
);

  logic [DVD_W-1:0]     dvd;
  logic [DEN_W-1:0]     dreg;
  logic [DEN_W-1:0]     rem;
  logic [63:0]          q;
  logic                 big;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DEN_W:0]       rem_sh;
  logic                 ge;
  logic [63:0]          q_next;

  always_comb begin
    rem_sh = {rem, dvd[DVD_W-1]};
    ge     = rem_sh >= {1'b0, dreg};
    q_next = {q[62:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DVD_W);
      dvd  <= {num, {DIV_SHIFT{1'b0}}};
      dreg <= den;
      rem  <= '0;
      q    <= '0;
      big  <= 1'b0;
    end else if (busy) begin
      dvd <= dvd << 1;
      rem <= ge ? DEN_W'(rem_sh - {1'b0, dreg}) : DEN_W'(rem_sh);
      q   <= q_next;
      if (q_next[63]) big <= 1'b1;
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) busy <= 1'b0;
    end
  end

  assign stat.busy = busy;
  assign mag       = big ? {1'b1, 63'd0} : q;

endmodule

// ===== hw/rtl/dpds_checker.sv =====
// Port-level checker for dipole_potential_direct_sum, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module dpds_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [63:0] potential,
  input logic               coincident_seen
);

  // every word keeps the block busy for at least the next cycle
  `DPDS_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall)
  `DPDS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(potential) && $stable(coincident_seen))
  // a result only appears at the end of a busy stretch
  `DPDS_ASSERT(a_out_from_busy, $rose(out_valid) |-> $past(in_stall))
  `DPDS_ASSERT_ALWAYS(a_reset_clear, rst |=> !out_valid && !in_stall)

endmodule

bind dipole_potential_direct_sum dpds_checker u_dpds_checker (.*);

// ===== verif/tb_top.sv =====
// Self-checking bench for dipole_potential_direct_sum: queued driver, clocked monitor,
// and a wide-integer model of the dipole sum. Depends only on the RTL and dpds_pkg.
module tb_top;
  import dpds_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] target_x = '0, target_y = '0, target_z = '0;
  logic signed [31:0] source_x = '0, source_y = '0, source_z = '0;
  logic signed [31:0] normal_x = '0, normal_y = '0, normal_z = '0;
  logic signed [31:0] density = '0;
  logic last_source = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [63:0] potential;
  logic coincident_seen;

  typedef struct {
    logic signed [31:0] tx, ty, tz, sx, sy, sz, nx, ny, nz, dens;
    logic last;
    logic drain;   // hold this word back until all results are in
  } src_word_t;

  typedef struct {
    logic [63:0] pot;
    logic        coin;
  } pot_result_t;

  src_word_t   pending_words[$];
  pot_result_t expected_pots[$];
  src_word_t   cur_word;
  logic [63:0] sum_model = '0;
  logic        coin_model = 1'b0;
  logic        word_taken = 1'b0;
  int unsigned cycle_cnt = 0, quiet_cycles = 0;
  int unsigned mismatches = 0, results_seen = 0, words_sent = 0, coin_results = 0;
  int unsigned sat_results = 0;

  dipole_potential_direct_sum u_dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] isqrt(input logic [127:0] x);
    logic [63:0] root, cand;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= x) root = cand;
    end
    return root;
  endfunction

  // Fold one source term into the running sum; on a last word queue the result.
  task automatic fold_source(input src_word_t w);
    logic signed [32:0] d;
    logic signed [65:0] sq;
    logic signed [66:0] p, dot;
    logic [65:0] r2;
    logic [66:0] dmag;
    logic [32:0] dens_mag;
    logic [127:0] num, den, len;
    logic [191:0] q;
    logic [63:0] mag, term, s;
    logic neg;
    logic signed [31:0] tv[3], sv[3], nv[3];
    pot_result_t r;
    tv = '{w.tx, w.ty, w.tz};
    sv = '{w.sx, w.sy, w.sz};
    nv = '{w.nx, w.ny, w.nz};
    r2 = '0;
    dot = '0;
    for (int a = 0; a < 3; a++) begin
      d = $signed({tv[a][31], tv[a]}) - $signed({sv[a][31], sv[a]});
      sq = d * d;
      r2 = r2 + sq;
      p = d * nv[a];
      dot = dot + p;
    end
    if (r2 == '0) begin
      coin_model = 1'b1;
    end else begin
      neg = dot[66] ^ w.dens[31];
      dmag = dot[66] ? -dot : dot;
      dens_mag = w.dens[31] ? -{w.dens[31], w.dens} : {1'b0, w.dens};
      num = {61'd0, dmag} * {95'd0, dens_mag};
      len = {64'd0, isqrt({30'd0, r2, 32'd0})};
      den = {62'd0, r2} * len;
      q = ({64'd0, num} << DIV_SHIFT) / {64'd0, den};
      mag = (q >= (192'd1 << 63)) ? (64'd1 << 63) : q[63:0];
      if (neg) term = ~mag + 64'd1;
      else term = mag[63] ? {1'b0, {63{1'b1}}} : mag;
      s = sum_model + term;
      if (sum_model[63] == term[63] && s[63] != sum_model[63])
        s = sum_model[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      sum_model = s;
    end
    if (w.last) begin
      r.pot = sum_model;
      r.coin = coin_model;
      expected_pots.push_back(r);
      sum_model = '0;
      coin_model = 1'b0;
    end
  endtask

  // Sender side: new word or idle at the falling edge.
  always @(negedge clk) begin
    if (!rst && (!in_valid || word_taken)) begin
      word_taken = 1'b0;
      if (pending_words.size() != 0 && (cycle_cnt inside {[30000:60000]}
          || $urandom_range(99) >= 26)
          && !(pending_words[0].drain && expected_pots.size() != 0)) begin
        cur_word = pending_words.pop_front();
        pending_words.push_front(cur_word);
        target_x <= cur_word.tx; target_y <= cur_word.ty; target_z <= cur_word.tz;
        source_x <= cur_word.sx; source_y <= cur_word.sy; source_z <= cur_word.sz;
        normal_x <= cur_word.nx; normal_y <= cur_word.ny; normal_z <= cur_word.nz;
        density <= cur_word.dens;
        last_source <= cur_word.last;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !(cycle_cnt inside {[30000:60000]}) && ($urandom_range(99) < 26);
  end

  // Accept on the sender side and check on the receiver side.
  always @(posedge clk) begin
    pot_result_t e;
    if (!rst) begin
      cycle_cnt++;
      quiet_cycles++;
      if (in_valid && !in_stall && !word_taken) begin
        cur_word = pending_words.pop_front();
        fold_source(cur_word);
        word_taken = 1'b1;
        words_sent++;
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        results_seen++;
        if (expected_pots.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: potential %h flag %b", potential, coincident_seen);
        end else begin
          e = expected_pots.pop_front();
          if (e.coin) coin_results++;
          if (e.pot == 64'h7fffffffffffffff || e.pot == 64'h8000000000000000) sat_results++;
          if (potential !== e.pot || coincident_seen !== e.coin) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: potential exp %h got %h, flag exp %b got %b",
                       e.pot, potential, e.coin, coincident_seen);
          end
        end
      end
      if (quiet_cycles >= 20000) begin
        $display("timeout waiting on handshake");
        $display("tb_top failed");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] pick_val();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(32'h3ffff)) - 32'sh20000;
      2: return $signed($urandom_range(4095)) - 32'sh800;
      3: return {$urandom_range(1) ? 1'b1 : 1'b0, {31{$urandom_range(1) ? 1'b1 : 1'b0}}};
      4: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(32'h3fffff)) - 32'sh200000;
    endcase
  endfunction

  task automatic add_word(input logic signed [31:0] t[3], input logic signed [31:0] s[3],
                          input logic signed [31:0] n[3], input logic signed [31:0] dn,
                          input logic lst, input logic drn);
    src_word_t w;
    w.tx = t[0]; w.ty = t[1]; w.tz = t[2];
    w.sx = s[0]; w.sy = s[1]; w.sz = s[2];
    w.nx = n[0]; w.ny = n[1]; w.nz = n[2];
    w.dens = dn; w.last = lst; w.drain = drn;
    pending_words.push_back(w);
  endtask

  initial begin
    logic signed [31:0] t[3], s[3], n[3];
    int run_len, total;
    localparam logic signed [31:0] MAXV = 32'sh7fffffff, MINV = 32'sh80000000;
    localparam logic signed [31:0] ONE_N = 32'sh40000000;
    // directed words
    add_word('{0, 0, 0}, '{0, 0, 0}, '{ONE_N, 0, 0}, 32'sh10000, 1'b1, 1'b0); // coincident only
    add_word('{32'sh10000, 0, 0}, '{0, 0, 0}, '{ONE_N, 0, 0}, 32'sh10000, 1'b1, 1'b0);
    add_word('{MAXV, MAXV, MAXV}, '{MINV, MINV, MINV}, '{MAXV, MAXV, MAXV}, MAXV, 1'b0, 1'b0);
    add_word('{MINV, MINV, MINV}, '{MAXV, MAXV, MAXV}, '{MINV, MINV, MINV}, MINV, 1'b1, 1'b0);
    // one-lsb distance with full density: term saturates, then sum saturates
    add_word('{1, 0, 0}, '{0, 0, 0}, '{MAXV, 0, 0}, MAXV, 1'b0, 1'b0);
    add_word('{1, 0, 0}, '{0, 0, 0}, '{MAXV, 0, 0}, MAXV, 1'b1, 1'b0);
    add_word('{1, 0, 0}, '{0, 0, 0}, '{MAXV, 0, 0}, MINV, 1'b0, 1'b0);
    add_word('{0, 1, 0}, '{0, 0, 0}, '{0, MINV, 0}, MAXV, 1'b0, 1'b0);
    add_word('{0, 0, 0}, '{0, 0, 0}, '{0, 0, MINV}, MAXV, 1'b1, 1'b0);    // coincident in run
    add_word('{0, 0, 32'sh20000}, '{0, 0, 0}, '{0, 0, ONE_N}, 0, 1'b1, 1'b1);
    add_word('{5, -3, 7}, '{-2, 9, 1}, '{0, 0, 0}, 32'sh30000, 1'b1, 1'b0);
    add_word('{32'sh10000, 32'sh10000, 0}, '{0, 0, 0}, '{ONE_N, -ONE_N, 0}, -32'sh10000,
             1'b1, 1'b0);
    // random runs sharing one target; a few carry a drain request
    total = 0;
    while (total < 690) begin
      run_len = $urandom_range(6, 1);
      foreach (t[a]) t[a] = pick_val();
      for (int k = 0; k < run_len; k++) begin
        foreach (s[a]) s[a] = ($urandom_range(9) == 0) ? t[a] : pick_val();
        foreach (n[a]) n[a] = pick_val();
        add_word(t, s, n, pick_val(), (k == run_len - 1) || ($urandom_range(19) == 0),
                 $urandom_range(49) == 0);
        total++;
      end
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (pending_words.size() == 0 && expected_pots.size() == 0);
    repeat (400) @(posedge clk);
    $display("%0d source words folded, %0d sums checked (%0d with a skipped term, %0d at a rail)",
             words_sent, results_seen, coin_results, sat_results);
    if (mismatches == 0 && expected_pots.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
